@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion forms for the resampler rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("next-cycle implication failed");

`endif

@@ rtl/vlr_pkg.sv @@
// ----------------------------------------------------------------------------
// vlr_pkg
// shared types and constants of the varispeed loop resampler
// ----------------------------------------------------------------------------
package vlr_pkg;

	// register indexes
	localparam logic [2:0] REG_SPEED = 3'd0;
	localparam logic [2:0] REG_MODE  = 3'd1;
	localparam logic [2:0] REG_LEN   = 3'd2;
	localparam logic [2:0] REG_FADE  = 3'd3;
	localparam logic [2:0] REG_DECAY = 3'd4;
	localparam logic [2:0] REG_FLOOR = 3'd5;

	// loop modes
	localparam logic [1:0] LM_NONE  = 2'd0;
	localparam logic [1:0] LM_PLAIN = 2'd1;
	localparam logic [1:0] LM_FADE  = 2'd2;
	localparam logic [1:0] LM_DECAY = 2'd3;

	// priming counter codes
	localparam logic [1:0] PRIME_NONE = 2'd0;
	localparam logic [1:0] PRIME_ONE  = 2'd1;
	localparam logic [1:0] PRIME_DONE = 2'd2;

	// seam ramp is at most an eighth of the loop
	localparam int SEAM_SHIFT  = 3;
	localparam int DECAY_SHIFT = 16;

	localparam logic [1:0]  MODE_RST  = 2'd0;
	localparam logic [31:0] LEN_RST   = 32'd0;
	localparam logic [15:0] FADE_RST  = 16'd256;
	localparam logic [15:0] DECAY_RST = 16'd58982;
	localparam logic [15:0] FLOOR_RST = 16'd655;
	localparam logic [31:0] POS_RST   = 32'd2;

	typedef struct packed {
		logic load;
		logic upd;
		logic env;
		logic div;
		logic mul;
		logic add;
		logic scl;
		logic emit;
	} vlr_cmd_t;

	typedef struct packed {
		logic emit_go;
		logic need_div;
		logic div_done;
		logic out_free;
		logic last;
	} vlr_sts_t;

endpackage

@@ rtl/vlr_cfg.sv @@
// ----------------------------------------------------------------------------
// vlr_cfg
// configuration register file, one write transaction per register
// ----------------------------------------------------------------------------
module vlr_cfg import vlr_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	output logic [FRAC_BITS+1:0] speed_step,
	output logic [1:0]           loop_mode,
	output logic [31:0]          loop_length,
	output logic [15:0]          fade_length,
	output logic [15:0]          decay_factor,
	output logic [15:0]          gain_floor
);

	localparam logic [FRAC_BITS+1:0] SPEED_RST = {2'b01, {FRAC_BITS{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_step   <= SPEED_RST;
			loop_mode    <= MODE_RST;
			loop_length  <= LEN_RST;
			fade_length  <= FADE_RST;
			decay_factor <= DECAY_RST;
			gain_floor   <= FLOOR_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SPEED: speed_step   <= cfg_data[FRAC_BITS+1:0];
				REG_MODE:  loop_mode    <= cfg_data[1:0];
				REG_LEN:   loop_length  <= cfg_data;
				REG_FADE:  fade_length  <= cfg_data[15:0];
				REG_DECAY: decay_factor <= cfg_data[15:0];
				REG_FLOOR: gain_floor   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/vlr_ctrl.sv @@
// ----------------------------------------------------------------------------
// vlr_ctrl
// sequencer: frame update, seam division, interpolation and output steps
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vlr_ctrl import vlr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  vlr_sts_t sts,
	output vlr_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_UPD  = 3'd1;
	localparam logic [2:0] S_ENV  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_INT  = 3'd4;
	localparam logic [2:0] S_ADD  = 3'd5;
	localparam logic [2:0] S_SCL  = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	logic [2:0] state_q, state_d;
	logic       acc;

	assign in_stall = (state_q != S_IDLE);
	assign acc      = in_valid && !in_stall;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		cmd.load = acc;
		case (state_q)
			S_IDLE: begin
				if (acc) state_d = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = sts.emit_go ? S_ENV : S_IDLE;
			end
			S_ENV: begin
				cmd.env = 1'b1;
				state_d = sts.need_div ? S_DIV : S_INT;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (sts.div_done) state_d = S_INT;
			end
			S_INT: begin
				cmd.mul = 1'b1;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.add = 1'b1;
				state_d = S_SCL;
			end
			S_SCL: begin
				cmd.scl = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = sts.last ? S_IDLE : S_INT;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ASSERT_NXT(a_acc_upd, clk, arst_n, acc, state_q == S_UPD)
	`ASSERT_NXT(a_last_idle, clk, arst_n, cmd.emit && sts.last, state_q == S_IDLE)
	`ASSERT_NXT(a_div_int, clk, arst_n, cmd.div && sts.div_done, state_q == S_INT)

endmodule

@@ rtl/vlr_dp.sv @@
// ----------------------------------------------------------------------------
// vlr_dp
// frame, phase, loop and gain state with the interpolation datapath
// ----------------------------------------------------------------------------
module vlr_dp import vlr_pkg::*; #(
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [SAMPLE_BITS-1:0] source_sample,
	input  logic                          restart,
	input  logic [FRAC_BITS+1:0]          speed_step,
	input  logic [1:0]                    loop_mode,
	input  logic [31:0]                   loop_length,
	input  logic [15:0]                   fade_length,
	input  logic [15:0]                   decay_factor,
	input  logic [15:0]                   gain_floor,
	input  logic                          out_stall,
	input  vlr_cmd_t                      cmd,
	output vlr_sts_t                      sts,
	output logic                          out_valid,
	output logic signed [SAMPLE_BITS-1:0] out_sample,
	output logic                          last_of_run,
	output logic                          stop_request
);

	localparam int S   = SAMPLE_BITS;
	localparam int F   = FRAC_BITS;
	localparam int PW  = F + 2;
	localparam int GW  = F + 1;
	localparam int DW  = S + 1;
	localparam int P1W = DW + F + 1;
	localparam int P2W = DW + GW + 1;
	localparam int CW  = $clog2(F);

	localparam logic [PW-1:0] PH_ONE  = {2'b01, {F{1'b0}}};
	localparam logic [PW-1:0] PH_HALF = {3'b001, {(F-1){1'b0}}};
	localparam logic [PW-1:0] PH_TWO  = {2'b10, {F{1'b0}}};
	localparam logic [GW-1:0] G_ONE   = {1'b1, {F{1'b0}}};
	localparam logic signed [P2W-1:0] SAT_HI = {{(P2W-S+1){1'b0}}, {(S-1){1'b1}}};
	localparam logic signed [P2W-1:0] SAT_LO = {{(P2W-S+1){1'b1}}, {(S-1){1'b0}}};

	logic signed [S-1:0]   smp_q, cur_q, nxt_q;
	logic                  rst_q;
	logic [PW-1:0]         phase_q;
	logic [31:0]           pos_q, f_q, rem_q;
	logic [GW-1:0]         gain_q, env_q;
	logic [1:0]            prime_q;
	logic                  stop_q, cnt_q;
	logic [F-1:0]          quo_q;
	logic [CW-1:0]         dcnt_q;
	logic signed [P1W-1:0] prod_s1;
	logic signed [DW-1:0]  v_s2;
	logic signed [P2W-1:0] prod_s3;

	// step clamp
	logic [PW-1:0] step_c;
	always_comb begin
		if (speed_step < PH_HALF)     step_c = PH_HALF;
		else if (speed_step > PH_TWO) step_c = PH_TWO;
		else                          step_c = speed_step;
	end

	// frame update terms
	logic                   prime0, track, wrap, below;
	logic [PW-1:0]          ph_sub;
	logic [32:0]            pos_nx;
	logic [GW+15:0]         gain_prod;
	logic [GW-1:0]          gain_new;
	logic [31:0]            f_c;
	assign prime0    = rst_q || (prime_q == PRIME_NONE);
	assign ph_sub    = (phase_q >= PH_ONE) ? phase_q - PH_ONE : phase_q;
	assign track     = (loop_length != 32'd0) && (loop_mode != LM_NONE);
	assign pos_nx    = {1'b0, pos_q} + 33'd1;
	assign wrap      = pos_nx >= {1'b0, loop_length};
	assign gain_prod = gain_q * decay_factor;
	assign gain_new  = GW'(gain_prod >> DECAY_SHIFT);
	assign below     = 32'(gain_new) < 32'(gain_floor);
	assign f_c = (loop_length >= 32'({fade_length, 3'b000})) ? 32'(fade_length)
		: (loop_length >> SEAM_SHIFT);

	// seam envelope terms
	logic        env_on, seam_lo, seam_hi;
	logic [31:0] num;
	assign env_on  = (loop_mode == LM_FADE) && (loop_length != 32'd0);
	assign seam_lo = pos_q < f_q;
	assign seam_hi = pos_q > (loop_length - f_q);
	assign num = seam_lo ? pos_q : ((pos_q >= loop_length) ? 32'd0 : loop_length - pos_q);

	// restoring division step
	logic [32:0]  rem2;
	logic         ge;
	logic [F-1:0] quo_n;
	assign rem2  = {rem_q, 1'b0};
	assign ge    = rem2 >= {1'b0, f_q};
	assign quo_n = {quo_q[F-2:0], ge};

	// interpolation and scaling
	logic signed [DW-1:0]  cur_x, diff;
	logic [GW-1:0]         scale;
	logic signed [P2W-1:0] sh;
	logic [PW-1:0]         ph_nx;
	assign cur_x = DW'(cur_q);
	assign diff  = DW'(nxt_q) - cur_x;
	assign scale = env_on ? env_q : ((loop_mode == LM_DECAY) ? gain_q : G_ONE);
	assign sh    = prod_s3 >>> F;
	assign ph_nx = phase_q + step_c;

	assign sts.emit_go  = !prime0 && ((prime_q == PRIME_ONE) || (ph_sub < PH_ONE));
	assign sts.need_div = env_on && (f_q != 32'd0) && (seam_lo || seam_hi);
	assign sts.div_done = dcnt_q == CW'(F - 1);
	assign sts.out_free = !out_valid || !out_stall;
	assign sts.last     = cnt_q || (ph_nx >= PH_ONE);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			smp_q <= source_sample;
			rst_q <= restart;
		end
		if (cmd.upd) f_q <= f_c;
		if (cmd.mul) prod_s1 <= diff * $signed({1'b0, phase_q[F-1:0]});
		if (cmd.add) v_s2 <= cur_x + DW'(prod_s1 >>> F);
		if (cmd.scl) prod_s3 <= v_s2 * $signed({1'b0, scale});
		if (cmd.env) begin
			rem_q  <= num;
			quo_q  <= '0;
			dcnt_q <= '0;
			env_q  <= G_ONE;
		end
		if (cmd.div) begin
			rem_q  <= ge ? 32'(rem2 - {1'b0, f_q}) : rem2[31:0];
			quo_q  <= quo_n;
			dcnt_q <= dcnt_q + CW'(1);
			if (sts.div_done) env_q <= {1'b0, quo_n};
		end
		if (cmd.emit) begin
			if (sh > SAT_HI)      out_sample <= SAT_HI[S-1:0];
			else if (sh < SAT_LO) out_sample <= SAT_LO[S-1:0];
			else                  out_sample <= sh[S-1:0];
			last_of_run  <= sts.last;
			stop_request <= stop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			nxt_q     <= '0;
			phase_q   <= '0;
			pos_q     <= POS_RST;
			gain_q    <= G_ONE;
			prime_q   <= PRIME_NONE;
			stop_q    <= 1'b0;
			cnt_q     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.upd) begin
				cnt_q <= 1'b0;
				if (prime0 || (prime_q == PRIME_ONE)) begin
					if (prime0) begin
						cur_q   <= smp_q;
						prime_q <= PRIME_ONE;
					end else begin
						nxt_q   <= smp_q;
						prime_q <= PRIME_DONE;
					end
					phase_q <= '0;
					pos_q   <= POS_RST;
					gain_q  <= G_ONE;
					stop_q  <= 1'b0;
				end else begin
					phase_q <= ph_sub;
					cur_q   <= nxt_q;
					nxt_q   <= smp_q;
					if (track) begin
						if (wrap) begin
							pos_q <= '0;
							if (loop_mode == LM_DECAY) begin
								gain_q <= below ? '0 : gain_new;
								if (below) stop_q <= 1'b1;
							end
						end else begin
							pos_q <= pos_nx[31:0];
						end
					end
				end
			end
			if (cmd.emit) begin
				phase_q   <= ph_nx;
				cnt_q     <= 1'b1;
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/varispeed_loop_resampler.sv @@
// ----------------------------------------------------------------------------
// varispeed_loop_resampler
// linear-interpolation varispeed playback of a looped source stream
// ----------------------------------------------------------------------------
// One source frame per input transaction gives zero, one or two output
// transactions. The block works on one frame at a time: the frame is taken
// in the idle state, the update state refreshes frame, phase, loop position
// and decay gain, the envelope state sets up the seam envelope when the frame
// gives output, and in faded mode near a seam a restoring divider runs; each
// output then passes through the multiply, add, scale and output register
// steps, and the output step waits while the output is stalled. Outputs sit in
// a register so a new frame may be taken while the last output waits.
// Configuration is to be written by the user only while idle; the block itself
// does not enforce this.
module varispeed_loop_resampler import vlr_pkg::*; #(
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input frames
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] source_sample,
	input  logic                          restart,
	// output samples
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] out_sample,
	output logic                          last_of_run,
	output logic                          stop_request,
	// register writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [31:0]                   cfg_data
);

	logic [FRAC_BITS+1:0] speed_step;
	logic [1:0]           loop_mode;
	logic [31:0]          loop_length;
	logic [15:0]          fade_length, decay_factor, gain_floor;
	vlr_cmd_t             cmd;
	vlr_sts_t             sts;

	// register writes always complete in one transaction
	assign cfg_ready = 1'b1;

	vlr_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.speed_step   (speed_step),
		.loop_mode    (loop_mode),
		.loop_length  (loop_length),
		.fade_length  (fade_length),
		.decay_factor (decay_factor),
		.gain_floor   (gain_floor)
	);

	// sequencer
	vlr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// state, divider, multiplier and output register
	vlr_dp #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.source_sample (source_sample),
		.restart       (restart),
		.speed_step    (speed_step),
		.loop_mode     (loop_mode),
		.loop_length   (loop_length),
		.fade_length   (fade_length),
		.decay_factor  (decay_factor),
		.gain_floor    (gain_floor),
		.out_stall     (out_stall),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_sample    (out_sample),
		.last_of_run   (last_of_run),
		.stop_request  (stop_request)
	);

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// checks the varispeed loop resampler against a behavioural model of its
// interpolation, loop tracking, seam fade and per-pass decay
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
	import vlr_pkg::*;

	localparam int SB = 24;
	localparam int FB = 16;
	localparam logic [31:0] ONE = 32'd1 << FB;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic signed [SB-1:0] sample;
		logic                 last;
		logic                 stop;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SB-1:0] source_sample = '0;
	logic restart = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SB-1:0] out_sample;
	logic last_of_run;
	logic stop_request;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	varispeed_loop_resampler dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// model copy of the registers and state
	logic [17:0] m_speed;
	logic [1:0]  m_mode;
	logic [31:0] m_len;
	logic [15:0] m_fade, m_decay, m_floor;
	longint m_cur, m_nxt;
	logic [31:0] m_phase, m_pos, m_gain;
	logic [1:0]  m_prime;
	logic        m_stop;

	res_t expected_q[$];
	int errors = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;  // no idling in the last part of the run

	function automatic longint floor_sh(longint v);
		return v >>> FB;  // arithmetic shift floors
	endfunction

	function automatic longint seam_gain(logic [31:0] pos);
		longint f, num, len;
		len = m_len;
		f = (len >= 8 * longint'(m_fade)) ? longint'(m_fade) : len / 8;
		if (f == 0) return ONE;
		if (pos < f) num = pos;
		else if (longint'(pos) > len - f) num = (pos >= len) ? 0 : len - pos;
		else return ONE;
		return (num << FB) / f;
	endfunction

	function automatic void loop_restart();
		m_phase = 0;
		m_pos = 2;
		m_gain = ONE;
		m_stop = 1'b0;
	endfunction

	// predicts the samples one source frame gives
	function automatic void predict_frame(logic signed [SB-1:0] smp, logic rst);
		logic [31:0] step;
		longint v;
		int n;
		res_t r;
		step = 32'(m_speed);
		if (step < ONE / 2) step = ONE / 2;
		if (step > 2 * ONE) step = 2 * ONE;
		if (rst || m_prime == PRIME_NONE) begin
			m_cur = smp;
			m_prime = PRIME_ONE;
			loop_restart();
			return;
		end
		if (m_prime == PRIME_ONE) begin
			m_nxt = smp;
			m_prime = PRIME_DONE;
			loop_restart();
		end else begin
			if (m_phase >= ONE) m_phase -= ONE;
			m_cur = m_nxt;
			m_nxt = smp;
			if (m_len != 0 && m_mode != LM_NONE) begin
				if (longint'(m_pos) + 1 >= longint'(m_len)) begin
					m_pos = 0;
					if (m_mode == LM_DECAY) begin
						m_gain = 32'((longint'(m_gain) * m_decay) >> 16);
						if (m_gain < m_floor) begin
							m_gain = 0;
							m_stop = 1'b1;
						end
					end
				end else begin
					m_pos++;
				end
			end
			if (m_phase >= ONE) return;
		end
		n = 0;
		while (m_phase < ONE && n < 2) begin
			v = m_cur + floor_sh((m_nxt - m_cur) * longint'(m_phase));
			if (m_mode == LM_FADE && m_len != 0) v = floor_sh(v * seam_gain(m_pos));
			else if (m_mode == LM_DECAY) v = floor_sh(v * longint'(m_gain));
			if (v > 8388607) v = 8388607;
			if (v < -8388608) v = -8388608;
			r.sample = v[SB-1:0];
			r.stop = m_stop;
			m_phase += step;
			n++;
			r.last = !(m_phase < ONE && n < 2);
			expected_q.push_back(r);
		end
	endfunction

	// one input transaction, at times with a random gap ahead of it unless quiet
	task automatic send_frame(logic signed [SB-1:0] smp, logic rst);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 13)) @(negedge clk);
		in_valid <= 1'b1;
		source_sample <= smp;
		restart <= rst;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_frame(smp, rst);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// waits until every expected sample has arrived, then for the divider
	task automatic drain();
		while (expected_q.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_SPEED: m_speed = val[17:0];
			REG_MODE:  m_mode = val[1:0];
			REG_LEN:   m_len = val;
			REG_FADE:  m_fade = val[15:0];
			REG_DECAY: m_decay = val[15:0];
			REG_FLOOR: m_floor = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic setup(logic [17:0] sp, logic [1:0] md, logic [31:0] len,
			logic [15:0] fd, logic [15:0] dc, logic [15:0] fl);
		drain();
		write_reg(REG_SPEED, 32'(sp));
		write_reg(REG_MODE, 32'(md));
		write_reg(REG_LEN, len);
		write_reg(REG_FADE, 32'(fd));
		write_reg(REG_DECAY, 32'(dc));
		write_reg(REG_FLOOR, 32'(fl));
	endtask

	function automatic logic signed [SB-1:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			default: return SB'($urandom);
		endcase
	endfunction

	// extremes of the sample field, restart mid-stream, speed saturation
	task automatic test_directed();
		setup(18'd0, LM_NONE, 0, 16'd256, 16'd58982, 16'd655);
		send_frame(24'sh7FFFFF, 1'b1);
		send_frame(24'sh800000, 1'b0);
		send_frame(24'sh7FFFFF, 1'b0);
		send_frame(24'sh000000, 1'b0);
		send_frame(24'sh800000, 1'b1);  // restart while primed
		send_frame(24'sh7FFFFF, 1'b0);
		setup(18'h3FFFF, LM_PLAIN, 3, 16'd0, 16'd0, 16'd0);
		repeat (6) send_frame(rand_sample(), 1'b0);  // fast playback skips
		setup(18'd65536, LM_FADE, 16, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		repeat (6) send_frame(rand_sample(), 1'b0);
		setup(18'd40000, LM_DECAY, 2, 16'd1, 16'd30000, 16'd20000);
		repeat (6) send_frame(24'sh7FFFFF, 1'b0);  // gain below floor
	endtask

	task automatic test_mode(logic [1:0] md, int frames);
		logic [31:0] len;
		case ($urandom_range(0, 3))
			0: len = 0;
			1: len = 32'hFFFFFFFF;
			default: len = $urandom_range(1, 40);
		endcase
		setup(18'($urandom_range(20000, 140000)), md, len, 16'($urandom_range(0, 6)),
			16'($urandom_range(30000, 65535)), 16'($urandom_range(0, 20000)));
		send_frame(rand_sample(), 1'b1);
		repeat (frames) send_frame(rand_sample(), $urandom_range(0, 60) == 0);
	endtask

	task automatic test_random();
		for (int i = 0; i < 24; i++) begin
			if (i == 20) quiet = 1'b1;
			test_mode(2'(i % 4), 72);
		end
	endtask

	// result checker and output stall generator
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected sample %0d", $time, out_sample);
				errors++;
			end else begin
				res_t e;
				e = expected_q.pop_front();
				if (e.sample !== out_sample)
					$display("%0t: out_sample exp %0d got %0d", $time, e.sample, out_sample);
				if (e.last !== last_of_run)
					$display("%0t: last_of_run exp %0b got %0b", $time, e.last, last_of_run);
				if (e.stop !== stop_request)
					$display("%0t: stop_request exp %0b got %0b", $time, e.stop, stop_request);
				if (e !== {out_sample, last_of_run, stop_request}) errors++;
			end
		end
	end

	int stall_left = 0;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 12);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		m_speed = 18'd65536;
		m_mode = MODE_RST;
		m_len = LEN_RST;
		m_fade = FADE_RST;
		m_decay = DECAY_RST;
		m_floor = FLOOR_RST;
		m_cur = 0;
		m_nxt = 0;
		m_prime = PRIME_NONE;
		loop_restart();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random();
		drain();
		if (errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/vlr_pkg.sv
rtl/vlr_cfg.sv
rtl/vlr_ctrl.sv
rtl/vlr_dp.sv
rtl/varispeed_loop_resampler.sv
dv/tb_top.sv
